>>> hdl/sbl_pkg.sv
// Package for the source byte lexer: types, token codes, keyword table and scan helpers.
package sbl_pkg;

   localparam int PosBits  = 16;
   localparam int KwCount  = 16;

   typedef logic [PosBits-1:0] pos_type;
   localparam pos_type PosMax = '1;
   localparam logic [15:0] LenMax = 16'hFFFF;

   typedef enum logic [3:0] {
      ModeIdle, ModeNumber, ModeNumDot, ModeFraction, ModeIdent,
      ModeString, ModeChar, ModeSlash, ModeComment, ModeOp
   } mode_type;

   // token kinds
   localparam logic [5:0] KindDot    = 6'd6;
   localparam logic [5:0] KindSlash  = 6'd9;
   localparam logic [5:0] KindBang   = 6'd11;
   localparam logic [5:0] KindAssign = 6'd13;
   localparam logic [5:0] KindLess   = 6'd15;
   localparam logic [5:0] KindGreat  = 6'd17;
   localparam logic [5:0] KindString = 6'd19;
   localparam logic [5:0] KindNumber = 6'd20;
   localparam logic [5:0] KindChar   = 6'd21;
   localparam logic [5:0] KindIdent  = 6'd22;
   localparam logic [5:0] KindKw0    = 6'd23;
   localparam logic [5:0] KindEnd    = 6'd39;
   localparam logic [5:0] KindError  = 6'd40;

   // error codes
   localparam logic [1:0] ErrNone         = 2'd0;
   localparam logic [1:0] ErrUnexpected   = 2'd1;
   localparam logic [1:0] ErrUnterminated = 2'd2;

   // characters
   localparam logic [7:0] ChNewline = 8'h0A;
   localparam logic [7:0] ChDot     = 8'h2E;
   localparam logic [7:0] ChSlash   = 8'h2F;
   localparam logic [7:0] ChQuote   = 8'h22;
   localparam logic [7:0] ChApos    = 8'h27;
   localparam logic [7:0] ChEqual   = 8'h3D;

   localparam logic [47:0] KwText [KwCount] = '{
      {"&&", 32'h0}, "struct", {"else", 16'h0}, {"false", 8'h0},
      {"for", 24'h0}, {"fun", 24'h0}, {"if", 32'h0}, {"null", 16'h0},
      {"||", 32'h0}, {"print", 8'h0}, "return", {"super", 8'h0},
      {"self", 16'h0}, {"true", 16'h0}, {"let", 24'h0}, {"while", 8'h0}
   };
   localparam logic [2:0] KwLen [KwCount] = '{
      3'd2, 3'd6, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd4,
      3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
   };

   typedef struct packed {
      logic [5:0]  kind;
      logic [1:0]  err;
      logic [15:0] offset;
      logic [15:0] length;
      logic [15:0] line;
      logic [15:0] column;
   } token_type;

   typedef struct packed {
      logic [1:0]          n;
      token_type [2:0]     t;
   } token_group_type;

   typedef struct packed {
      mode_type        mode;
      logic [7:0]      held;
      pos_type         offset;
      pos_type         line;
      pos_type         column;
      pos_type         start_offset;
      pos_type         start_line;
      pos_type         start_column;
      logic [15:0]     length;
      logic [KwCount-1:0] kw;
   } lex_state_type;

   typedef struct packed {
      lex_state_type st;
      logic          v;
      token_type     tok;
   } idle_res_type;

   function automatic lex_state_type reset_state();
      lex_state_type s;
      s.mode         = ModeIdle;
      s.held         = 8'h00;
      s.offset       = '0;
      s.line         = PosBits'(1);
      s.column       = '0;
      s.start_offset = '0;
      s.start_line   = PosBits'(1);
      s.start_column = '0;
      s.length       = 16'h0000;
      s.kw           = '1;
      return s;
   endfunction

   function automatic pos_type sat_inc(pos_type v);
      return (v == PosMax) ? v : v + PosBits'(1);
   endfunction

   function automatic logic [15:0] fld(pos_type p);
      logic [31:0] w;
      w = 32'(p);
      return w[15:0];
   endfunction

   function automatic lex_state_type take_fn(lex_state_type si, logic [7:0] b);
      lex_state_type s;
      s = si;
      s.offset = sat_inc(si.offset);
      if (b == ChNewline) begin
         s.line   = sat_inc(si.line);
         s.column = '0;
      end else begin
         s.column = sat_inc(si.column);
      end
      s.length = (si.length == LenMax) ? si.length : si.length + 16'd1;
      return s;
   endfunction

   function automatic lex_state_type begin_fn(lex_state_type si);
      lex_state_type s;
      s = si;
      s.start_offset = si.offset;
      s.start_line   = si.line;
      s.start_column = si.column;
      s.length       = 16'h0000;
      return s;
   endfunction

   function automatic logic is_num(logic [7:0] b);
      return (b >= "0" && b <= "9") || b == "_";
   endfunction

   function automatic logic is_word_char(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
             b == "_" || b == "&" || b == "|";
   endfunction

   function automatic logic [7:0] kw_byte(int k, logic [2:0] p);
      logic [7:0] c;
      case (p)
         3'd0: c = KwText[k][47:40];
         3'd1: c = KwText[k][39:32];
         3'd2: c = KwText[k][31:24];
         3'd3: c = KwText[k][23:16];
         3'd4: c = KwText[k][15:8];
         3'd5: c = KwText[k][7:0];
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [KwCount-1:0] narrow_fn(logic [KwCount-1:0] kw,
                                                    logic [7:0] b, logic [15:0] len);
      logic [KwCount-1:0] r;
      r = kw;
      for (int k = 0; k < KwCount; k++) begin
         if (len >= 16'(KwLen[k]) || kw_byte(k, len[2:0]) != b) r[k] = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [5:0] ident_kind(lex_state_type s);
      logic [5:0] kd;
      kd = KindIdent;
      for (int k = KwCount - 1; k >= 0; k--) begin
         if (s.kw[k] && s.length == 16'(KwLen[k])) kd = KindKw0 + 6'(k);
      end
      return kd;
   endfunction

   function automatic logic [5:0] single_kind(logic [7:0] b);
      logic [5:0] kd;
      case (b)
         "(": kd = 6'd0;
         ")": kd = 6'd1;
         "{": kd = 6'd2;
         "}": kd = 6'd3;
         ";": kd = 6'd4;
         ",": kd = 6'd5;
         ".": kd = KindDot;
         "-": kd = 6'd7;
         "+": kd = 6'd8;
         "*": kd = 6'd10;
         default: kd = 6'h3F;
      endcase
      return kd;
   endfunction

   function automatic logic [5:0] op_kind(logic [7:0] b);
      logic [5:0] kd;
      case (b)
         "!": kd = KindBang;
         "=": kd = KindAssign;
         "<": kd = KindLess;
         default: kd = KindGreat;
      endcase
      return kd;
   endfunction

   function automatic token_type pend(lex_state_type s, logic [5:0] kd, logic [1:0] e);
      token_type t;
      t.kind   = kd;
      t.err    = e;
      t.offset = fld(s.start_offset);
      t.length = s.length;
      t.line   = fld(s.start_line);
      t.column = fld(s.start_column);
      return t;
   endfunction

   function automatic idle_res_type idle_fn(lex_state_type si, logic [7:0] b);
      idle_res_type r;
      logic [5:0]   sk;
      sk = single_kind(b);
      r.st = si;
      r.st.mode = ModeIdle;
      r.v = 1'b0;
      r.tok = '0;
      if (b == " " || b == 8'h09 || b == 8'h0D || b == ChNewline) begin
         r.st = take_fn(r.st, b);
      end else if (is_num(b)) begin
         r.st = take_fn(begin_fn(r.st), b);
         r.st.mode = ModeNumber;
      end else if (is_word_char(b)) begin
         r.st = begin_fn(r.st);
         r.st.kw = narrow_fn('1, b, 16'h0000);
         r.st = take_fn(r.st, b);
         r.st.mode = ModeIdent;
      end else if (sk != 6'h3F) begin
         r.st = take_fn(begin_fn(r.st), b);
         r.tok = pend(r.st, sk, ErrNone);
         r.v = 1'b1;
      end else if (b == ChSlash) begin
         r.st = take_fn(begin_fn(r.st), b);
         r.st.mode = ModeSlash;
      end else if (b == "!" || b == "=" || b == "<" || b == ">") begin
         r.st = take_fn(begin_fn(r.st), b);
         r.st.held = b;
         r.st.mode = ModeOp;
      end else if (b == ChQuote) begin
         r.st = take_fn(begin_fn(r.st), b);
         r.st.mode = ModeString;
      end else if (b == ChApos) begin
         r.st = begin_fn(take_fn(r.st, b));
         r.st.mode = ModeChar;
      end else begin
         r.st = take_fn(begin_fn(r.st), b);
         r.tok = pend(r.st, KindError, ErrUnexpected);
         r.v = 1'b1;
      end
      return r;
   endfunction

endpackage

>>> hdl/source_byte_lexer_core.sv
// Source byte lexer top level: input register, scan step, result register.
//
// Usage:
//  - req channel: one word per cycle, a source byte or an end marker
//    (req_end_of_source high). A word is taken when req_valid is high and
//    req_stall is low.
//  - rsp channel: tokens with kind, error code, offset, length, line and
//    column; rsp_last flags the final token caused by one request word.
//    A word that only extends a token, or is blank or comment text,
//    causes no token. One word causes at most three tokens.
//  - Path: a word is held in the input register, and its tokens are offered
//    from the result register once that register can take the group.
//  - Throughput: one word per cycle while each word causes at most one
//    token and rsp_stall is low; tokens leave one per cycle while rsp_stall
//    is low, so a word causing more stalls the input until its last token leaves.
//  - Stall: when rsp_stall holds a token back, the next word waits
//    in the input register and req_stall rises; nothing is lost.
//  - Reset: synchronous, active high; scan state returns to the start of
//    a source (line 1, column 0, offset 0) and both registers empty.
//    The end marker also returns the scanner to that state.
module source_byte_lexer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_source_byte,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [1:0]  rsp_error_kind,
   output logic [15:0] rsp_token_offset,
   output logic [15:0] rsp_token_length,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic        rsp_last
);

   // input register
   logic                     in_valid_ff;
   logic [7:0]               in_byte_ff;
   logic                     in_end_ff;

   // scanner state
   sbl_pkg::lex_state_type   state_ff;
   sbl_pkg::lex_state_type   state_in;

   sbl_pkg::token_group_type group;
   sbl_pkg::token_type       head;
   logic                     load_ok;
   logic                     fire;

   // a held word is scanned once the result register can take its group
   assign fire      = in_valid_ff && load_ok;
   assign req_stall = in_valid_ff && !load_ok;

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_source_byte;
         in_end_ff  <= req_end_of_source;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= sbl_pkg::reset_state();
      end else begin
         if (!req_stall) in_valid_ff <= req_valid;
         if (fire) state_ff <= state_in;
      end
   end

   sbl_step u_step (
      .state_cur (state_ff),
      .byte_cur  (in_byte_ff),
      .end_cur   (in_end_ff),
      .state_in  (state_in),
      .group     (group)
   );

   sbl_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .group     (group),
      .rsp_stall (rsp_stall),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .head      (head),
      .last      (rsp_last)
   );

   assign rsp_token_kind    = head.kind;
   assign rsp_error_kind    = head.err;
   assign rsp_token_offset  = head.offset;
   assign rsp_token_length  = head.length;
   assign rsp_line_number   = head.line;
   assign rsp_column_number = head.column;

`ifndef SYNTHESIS
   // input only backs up behind a pending token
   a_stall_has_token: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid) else $error("input stalled with empty result register");

   // end marker always yields at least the end token
   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (fire && in_end_ff) |-> (group.n != 2'd0)) else $error("end marker without token");

   // end marker restarts the source position
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (fire && in_end_ff) |=> (state_ff.mode == sbl_pkg::ModeIdle && state_ff.offset == '0))
      else $error("scanner not restarted after end marker");
`endif

endmodule

>>> hdl/sbl_step.sv
// Scan step: next lexer state and the up to three tokens caused by one word.
module sbl_step (
   input  sbl_pkg::lex_state_type   state_cur,
   input  logic [7:0]               byte_cur,
   input  logic                     end_cur,
   output sbl_pkg::lex_state_type   state_in,
   output sbl_pkg::token_group_type group
);

   sbl_pkg::lex_state_type   s;
   sbl_pkg::token_group_type g;
   sbl_pkg::idle_res_type    r;
   sbl_pkg::token_type       t;

   always_comb begin
      s = state_cur;
      g = '0;
      r = '0;
      t = '0;
      if (end_cur) begin
         case (s.mode)
            sbl_pkg::ModeNumber, sbl_pkg::ModeFraction: begin
               g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::KindNumber, sbl_pkg::ErrNone);
               g.n = g.n + 2'd1;
            end
            sbl_pkg::ModeNumDot: begin
               g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::KindNumber, sbl_pkg::ErrNone);
               g.n = g.n + 2'd1;
               r = sbl_pkg::idle_fn(s, sbl_pkg::ChDot);
               s = r.st;
               g.t[g.n] = r.tok;
               g.n = g.n + 2'd1;
            end
            sbl_pkg::ModeIdent: begin
               g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::ident_kind(s), sbl_pkg::ErrNone);
               g.n = g.n + 2'd1;
            end
            sbl_pkg::ModeString: begin
               g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::KindError, sbl_pkg::ErrUnterminated);
               g.n = g.n + 2'd1;
            end
            sbl_pkg::ModeChar: begin
               g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::KindChar, sbl_pkg::ErrNone);
               g.n = g.n + 2'd1;
            end
            sbl_pkg::ModeSlash: begin
               g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::KindSlash, sbl_pkg::ErrNone);
               g.n = g.n + 2'd1;
            end
            sbl_pkg::ModeOp: begin
               g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::op_kind(s.held), sbl_pkg::ErrNone);
               g.n = g.n + 2'd1;
            end
            default: ;
         endcase
         t.kind   = sbl_pkg::KindEnd;
         t.err    = sbl_pkg::ErrNone;
         t.offset = sbl_pkg::fld(s.offset);
         t.length = 16'h0000;
         t.line   = sbl_pkg::fld(s.line);
         t.column = sbl_pkg::fld(s.column);
         g.t[g.n] = t;
         g.n = g.n + 2'd1;
         s = sbl_pkg::reset_state();
      end else begin
         case (s.mode)
            sbl_pkg::ModeNumber, sbl_pkg::ModeFraction: begin
               if (sbl_pkg::is_num(byte_cur)) begin
                  s = sbl_pkg::take_fn(s, byte_cur);
               end else if (s.mode == sbl_pkg::ModeNumber && byte_cur == sbl_pkg::ChDot) begin
                  s.held = byte_cur;
                  s.mode = sbl_pkg::ModeNumDot;
               end else begin
                  g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::KindNumber, sbl_pkg::ErrNone);
                  g.n = g.n + 2'd1;
                  r = sbl_pkg::idle_fn(s, byte_cur);
                  s = r.st;
                  if (r.v) begin
                     g.t[g.n] = r.tok;
                     g.n = g.n + 2'd1;
                  end
               end
            end
            sbl_pkg::ModeNumDot: begin
               if (sbl_pkg::is_num(byte_cur)) begin
                  s = sbl_pkg::take_fn(sbl_pkg::take_fn(s, sbl_pkg::ChDot), byte_cur);
                  s.mode = sbl_pkg::ModeFraction;
               end else begin
                  g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::KindNumber, sbl_pkg::ErrNone);
                  g.n = g.n + 2'd1;
                  r = sbl_pkg::idle_fn(s, sbl_pkg::ChDot);
                  g.t[g.n] = r.tok;
                  g.n = g.n + 2'd1;
                  r = sbl_pkg::idle_fn(r.st, byte_cur);
                  s = r.st;
                  if (r.v) begin
                     g.t[g.n] = r.tok;
                     g.n = g.n + 2'd1;
                  end
               end
            end
            sbl_pkg::ModeIdent: begin
               if (sbl_pkg::is_num(byte_cur) || sbl_pkg::is_word_char(byte_cur)) begin
                  s.kw = sbl_pkg::narrow_fn(s.kw, byte_cur, s.length);
                  s = sbl_pkg::take_fn(s, byte_cur);
               end else begin
                  g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::ident_kind(s), sbl_pkg::ErrNone);
                  g.n = g.n + 2'd1;
                  r = sbl_pkg::idle_fn(s, byte_cur);
                  s = r.st;
                  if (r.v) begin
                     g.t[g.n] = r.tok;
                     g.n = g.n + 2'd1;
                  end
               end
            end
            sbl_pkg::ModeString: begin
               s = sbl_pkg::take_fn(s, byte_cur);
               if (byte_cur == sbl_pkg::ChQuote) begin
                  g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::KindString, sbl_pkg::ErrNone);
                  g.n = g.n + 2'd1;
                  s.mode = sbl_pkg::ModeIdle;
               end
            end
            sbl_pkg::ModeChar: begin
               s = sbl_pkg::take_fn(s, byte_cur);
               g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::KindChar, sbl_pkg::ErrNone);
               g.n = g.n + 2'd1;
               s.mode = sbl_pkg::ModeIdle;
            end
            sbl_pkg::ModeSlash: begin
               if (byte_cur == sbl_pkg::ChSlash) begin
                  s = sbl_pkg::take_fn(s, byte_cur);
                  s.mode = sbl_pkg::ModeComment;
               end else begin
                  g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::KindSlash, sbl_pkg::ErrNone);
                  g.n = g.n + 2'd1;
                  r = sbl_pkg::idle_fn(s, byte_cur);
                  s = r.st;
                  if (r.v) begin
                     g.t[g.n] = r.tok;
                     g.n = g.n + 2'd1;
                  end
               end
            end
            sbl_pkg::ModeComment: begin
               s = sbl_pkg::take_fn(s, byte_cur);
               if (byte_cur == sbl_pkg::ChNewline) s.mode = sbl_pkg::ModeIdle;
            end
            sbl_pkg::ModeOp: begin
               if (byte_cur == sbl_pkg::ChEqual) begin
                  s = sbl_pkg::take_fn(s, byte_cur);
                  g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::op_kind(s.held) + 6'd1,
                                           sbl_pkg::ErrNone);
                  g.n = g.n + 2'd1;
                  s.mode = sbl_pkg::ModeIdle;
               end else begin
                  g.t[g.n] = sbl_pkg::pend(s, sbl_pkg::op_kind(s.held), sbl_pkg::ErrNone);
                  g.n = g.n + 2'd1;
                  r = sbl_pkg::idle_fn(s, byte_cur);
                  s = r.st;
                  if (r.v) begin
                     g.t[g.n] = r.tok;
                     g.n = g.n + 2'd1;
                  end
               end
            end
            default: begin
               r = sbl_pkg::idle_fn(s, byte_cur);
               s = r.st;
               if (r.v) begin
                  g.t[g.n] = r.tok;
                  g.n = g.n + 2'd1;
               end
            end
         endcase
      end
      state_in = s;
      group    = g;
   end

endmodule

>>> hdl/sbl_out_queue.sv
// Result register: holds one group of up to three tokens and hands them out in order.
module sbl_out_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  sbl_pkg::token_group_type group,
   input  logic                     rsp_stall,
   output logic                     load_ok,
   output logic                     rsp_valid,
   output sbl_pkg::token_type       head,
   output logic                     last
);

   sbl_pkg::token_type [2:0] slot_ff;
   sbl_pkg::token_type [2:0] slot_in;
   logic [1:0]               count_ff;
   logic [1:0]               count_in;
   logic                     pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign load_ok   = (count_ff == 2'd0) || (count_ff == 2'd1 && !rsp_stall);
   assign head      = slot_ff[0];
   assign last      = (count_ff == 2'd1);

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (load) begin
         slot_in  = group.t;
         count_in = group.n;
      end else if (pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         count_in   = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> bench/tb_source_byte_lexer_core.sv
// Testbench for the source byte lexer: directed table plus random source text, scoreboarded.
module tb_source_byte_lexer_core;

   // scan modes of the local tokenizer copy
   typedef enum logic [3:0] {
      ScIdle, ScNumber, ScNumDot, ScFraction, ScIdent,
      ScString, ScChar, ScSlash, ScComment, ScOp
   } scan_type;

   // one token as the block reports it
   typedef struct packed {
      logic [5:0]  kind;
      logic [1:0]  err;
      logic [15:0] offset;
      logic [15:0] length;
      logic [15:0] line;
      logic [15:0] column;
      logic        last;
   } tok_word_type;

   // one directed row: input word plus an optional typed-in first token
   typedef struct {
      logic [7:0] byte_val;
      logic       eos;
      logic       typed;
      logic [5:0] kind;
      logic [1:0] err;
   } row_type;

   localparam int NumRows = 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_source_byte = 8'h00;
   logic        req_end_of_source = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [1:0]  rsp_error_kind;
   logic [15:0] rsp_token_offset;
   logic [15:0] rsp_token_length;
   logic [15:0] rsp_line_number;
   logic [15:0] rsp_column_number;
   logic        rsp_last;

   // tokenizer copy state
   scan_type    lx_mode;
   logic [7:0]  lx_held;
   logic [15:0] lx_off, lx_line, lx_col, lx_soff, lx_sline, lx_scol, lx_len;
   logic [15:0] lx_kw;

   tok_word_type token_queue[$];   // tokens still owed by the block
   tok_word_type step_toks[$];     // tokens from the word now being scanned
   int          mismatch_count = 0;
   bit          hold_off = 1'b0;   // receiver long hold-off request
   bit          sending_done = 1'b0;

   string kw_words[16] = '{"&&", "struct", "else", "false", "for", "fun", "if", "null",
                           "||", "print", "return", "super", "self", "true", "let", "while"};

   source_byte_lexer_core i_dut (.*);

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // Tokenizer copy. Positions saturate; a held dot waits for a digit.
   // ---------------------------------------------------------------
   function automatic logic [15:0] inc16(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic void lx_reset();
      lx_mode = ScIdle; lx_held = 8'h00;
      lx_off = 16'd0; lx_line = 16'd1; lx_col = 16'd0;
      lx_soff = 16'd0; lx_sline = 16'd1; lx_scol = 16'd0; lx_len = 16'd0; lx_kw = '1;
   endfunction

   function automatic void lx_take(logic [7:0] b);
      lx_off = inc16(lx_off);
      if (b == sbl_pkg::ChNewline) begin
         lx_line = inc16(lx_line); lx_col = 16'd0;
      end else begin
         lx_col = inc16(lx_col);
      end
      lx_len = inc16(lx_len);
   endfunction

   function automatic void lx_mark();
      lx_soff = lx_off; lx_sline = lx_line; lx_scol = lx_col; lx_len = 16'd0;
   endfunction

   function automatic void lx_emit(logic [5:0] k, logic [1:0] e, logic [15:0] o,
                                   logic [15:0] l, logic [15:0] ln, logic [15:0] c);
      tok_word_type t;
      if (step_toks.size() >= 3) return;
      t = '{k, e, o, l, ln, c, 1'b0};
      step_toks.push_back(t);
   endfunction

   function automatic void lx_pending(logic [5:0] k, logic [1:0] e);
      lx_emit(k, e, lx_soff, lx_len, lx_sline, lx_scol);
   endfunction

   function automatic bit digitish(logic [7:0] b);
      return (b >= "0" && b <= "9") || b == "_";
   endfunction

   function automatic bit letterish(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
             b == "_" || b == "&" || b == "|";
   endfunction

   // drop keyword candidates that disagree with byte b at the current length
   function automatic void lx_narrow(logic [7:0] b);
      string w;
      for (int k = 0; k < 16; k++) begin
         w = kw_words[k];
         if (lx_len >= w.len() || w[lx_len] != b) lx_kw[k] = 1'b0;
      end
   endfunction

   function automatic logic [5:0] lx_word_kind();
      for (int k = 0; k < 16; k++)
         if (lx_kw[k] && kw_words[k].len() == lx_len) return sbl_pkg::KindKw0 + 6'(k);
      return sbl_pkg::KindIdent;
   endfunction

   function automatic logic [5:0] punct_kind(logic [7:0] b);
      case (b)
         "(": return 6'd0;
         ")": return 6'd1;
         "{": return 6'd2;
         "}": return 6'd3;
         ";": return 6'd4;
         ",": return 6'd5;
         ".": return sbl_pkg::KindDot;
         "-": return 6'd7;
         "+": return 6'd8;
         "*": return 6'd10;
         default: return 6'h3F;
      endcase
   endfunction

   function automatic logic [5:0] cmp_kind(logic [7:0] b);
      case (b)
         "!": return sbl_pkg::KindBang;
         "=": return sbl_pkg::KindAssign;
         "<": return sbl_pkg::KindLess;
         default: return sbl_pkg::KindGreat;
      endcase
   endfunction

   function automatic void lx_idle(logic [7:0] b);
      logic [5:0] pk;
      pk = punct_kind(b);
      lx_mode = ScIdle;
      if (b == " " || b == 8'h09 || b == 8'h0D || b == sbl_pkg::ChNewline) begin
         lx_take(b);
      end else if (digitish(b)) begin
         lx_mark(); lx_take(b); lx_mode = ScNumber;
      end else if (letterish(b)) begin
         lx_mark(); lx_kw = '1; lx_narrow(b); lx_take(b); lx_mode = ScIdent;
      end else if (pk != 6'h3F) begin
         lx_mark(); lx_take(b); lx_pending(pk, sbl_pkg::ErrNone);
      end else if (b == sbl_pkg::ChSlash) begin
         lx_mark(); lx_take(b); lx_mode = ScSlash;
      end else if (b == "!" || b == "=" || b == "<" || b == ">") begin
         lx_mark(); lx_take(b); lx_held = b; lx_mode = ScOp;
      end else if (b == sbl_pkg::ChQuote) begin
         lx_mark(); lx_take(b); lx_mode = ScString;
      end else if (b == sbl_pkg::ChApos) begin
         // char literal starts after the quote
         lx_take(b); lx_mark(); lx_mode = ScChar;
      end else begin
         lx_mark(); lx_take(b); lx_pending(sbl_pkg::KindError, sbl_pkg::ErrUnexpected);
      end
   endfunction

   // scan one word and push the tokens it produces onto the expected queue
   function automatic void lex_word(logic [7:0] b, logic eos);
      step_toks.delete();
      if (eos) begin
         case (lx_mode)
            ScNumber, ScFraction: lx_pending(sbl_pkg::KindNumber, sbl_pkg::ErrNone);
            ScNumDot: begin
               lx_pending(sbl_pkg::KindNumber, sbl_pkg::ErrNone); lx_idle(sbl_pkg::ChDot);
            end
            ScIdent:  lx_pending(lx_word_kind(), sbl_pkg::ErrNone);
            ScString: lx_pending(sbl_pkg::KindError, sbl_pkg::ErrUnterminated);
            ScChar:   lx_pending(sbl_pkg::KindChar, sbl_pkg::ErrNone);
            ScSlash:  lx_pending(sbl_pkg::KindSlash, sbl_pkg::ErrNone);
            ScOp:     lx_pending(cmp_kind(lx_held), sbl_pkg::ErrNone);
            default: ;
         endcase
         lx_emit(sbl_pkg::KindEnd, sbl_pkg::ErrNone, lx_off, 16'd0, lx_line, lx_col);
         lx_reset();
      end else begin
         case (lx_mode)
            ScNumber:
               if (digitish(b)) lx_take(b);
               else if (b == sbl_pkg::ChDot) begin
                  lx_held = b; lx_mode = ScNumDot;
               end else begin
                  lx_pending(sbl_pkg::KindNumber, sbl_pkg::ErrNone); lx_idle(b);
               end
            ScNumDot:
               if (digitish(b)) begin
                  lx_take(sbl_pkg::ChDot); lx_take(b); lx_mode = ScFraction;
               end else begin
                  lx_pending(sbl_pkg::KindNumber, sbl_pkg::ErrNone);
                  lx_idle(sbl_pkg::ChDot); lx_idle(b);
               end
            ScFraction:
               if (digitish(b)) lx_take(b);
               else begin
                  lx_pending(sbl_pkg::KindNumber, sbl_pkg::ErrNone); lx_idle(b);
               end
            ScIdent:
               if (digitish(b) || letterish(b)) begin
                  lx_narrow(b); lx_take(b);
               end else begin
                  lx_pending(lx_word_kind(), sbl_pkg::ErrNone); lx_idle(b);
               end
            ScString: begin
               lx_take(b);
               if (b == sbl_pkg::ChQuote) begin
                  lx_pending(sbl_pkg::KindString, sbl_pkg::ErrNone); lx_mode = ScIdle;
               end
            end
            ScChar: begin
               lx_take(b); lx_pending(sbl_pkg::KindChar, sbl_pkg::ErrNone); lx_mode = ScIdle;
            end
            ScSlash:
               if (b == sbl_pkg::ChSlash) begin
                  lx_take(b); lx_mode = ScComment;
               end else begin
                  lx_pending(sbl_pkg::KindSlash, sbl_pkg::ErrNone); lx_idle(b);
               end
            ScComment: begin
               lx_take(b);
               if (b == sbl_pkg::ChNewline) lx_mode = ScIdle;
            end
            ScOp:
               if (b == sbl_pkg::ChEqual) begin
                  lx_take(b); lx_pending(cmp_kind(lx_held) + 6'd1, sbl_pkg::ErrNone);
                  lx_mode = ScIdle;
               end else begin
                  lx_pending(cmp_kind(lx_held), sbl_pkg::ErrNone); lx_idle(b);
               end
            default: lx_idle(b);
         endcase
      end
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
      foreach (step_toks[i]) token_queue.push_back(step_toks[i]);
   endfunction

   // ---------------------------------------------------------------
   // Sender. Each word goes through the copy at its accepting edge.
   // ---------------------------------------------------------------
   task automatic send_word(logic [7:0] b, logic eos);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source_byte <= b;
      req_end_of_source <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lex_word(b, eos);
   endtask

   // feed a whole string of source text
   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   // byte picked to land in interesting lexer classes most of the time
   function automatic logic [7:0] pick_byte();
      string alphabet;
      alphabet = "abcefilnoprstuwhyAZ_09&|(){};,.-+*/!=<>\"'\n \t\r";
      case ($urandom_range(0, 9))
         0: return 8'($urandom_range(0, 255));
         default: return alphabet[$urandom_range(0, alphabet.len() - 1)];
      endcase
   endfunction

   // a well-formed lexeme with random content
   function automatic string pick_lexeme();
      string s;
      string ops;
      int n;
      s = "";
      ops = "!<>=";
      case ($urandom_range(0, 7))
         0: s = kw_words[$urandom_range(0, 15)];
         1: begin
            n = $urandom_range(1, 4);
            repeat (n) s = {s, string'(8'($urandom_range("0", "9")))};
            if ($urandom_range(0, 1)) s = {s, ".", string'(8'($urandom_range("0", "9")))};
         end
         2: begin
            n = $urandom_range(0, 6);
            s = "\"";
            repeat (n) s = {s, string'(pick_byte() == sbl_pkg::ChQuote ? "x" : "y")};
            if ($urandom_range(0, 3) == 0) s = {s, "\n"};
            s = {s, "\""};
         end
         3: s = {"'", string'(8'($urandom_range(32, 126)))};
         4: s = "// note\n";
         5: begin
            s = string'(ops[$urandom_range(0, 3)]);
            if ($urandom_range(0, 1)) s = {s, "="};
         end
         6: s = {"id", string'(8'($urandom_range("a", "z")))};
         default: s = string'(pick_byte());
      endcase
      return {s, string'(($urandom_range(0, 2) == 0) ? "\n" : " ")};
   endfunction

   // ---------------------------------------------------------------
   // Receiver: random stall per token, plus a long hold-off on request.
   // ---------------------------------------------------------------
   initial begin
      int w;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            w = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
               rsp_stall <= 1'b1;
               repeat (w) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // checker: each accepted token against the oldest expected token
   always @(posedge clock) begin
      tok_word_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_token_kind, rsp_error_kind, rsp_token_offset, rsp_token_length,
                 rsp_line_number, rsp_column_number, rsp_last};
         if (token_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected token %p", got);
         end else begin
            want = token_queue.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("token mismatch: want %p got %p", want, got);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      row_type rows[NumRows];
      tok_word_type first;
      lx_reset();
      // directed rows; typed-in kinds are checked against the copy too
      rows = '{
         '{8'h00, 1'b0, 1'b1, sbl_pkg::KindError, sbl_pkg::ErrUnexpected}, // NUL is unexpected
         '{8'hFF, 1'b0, 1'b1, sbl_pkg::KindError, sbl_pkg::ErrUnexpected}, // high byte too
         '{"(",   1'b0, 1'b1, 6'd0, sbl_pkg::ErrNone},
         '{"*",   1'b0, 1'b1, 6'd10, sbl_pkg::ErrNone},
         '{"!",   1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},
         '{"=",   1'b0, 1'b1, 6'd12, sbl_pkg::ErrNone},                 // !=
         '{">",   1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},
         '{" ",   1'b0, 1'b1, sbl_pkg::KindGreat, sbl_pkg::ErrNone},    // > then blank
         '{"1",   1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},
         '{".",   1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},
         '{";",   1'b0, 1'b1, sbl_pkg::KindNumber, sbl_pkg::ErrNone},   // dot without digit: 3 tokens
         '{"/",   1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},
         '{"/",   1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},
         '{"z",   1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},
         '{"\n",  1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},                  // comment ends
         '{"'",   1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},
         '{"\n",  1'b0, 1'b1, sbl_pkg::KindChar, sbl_pkg::ErrNone},     // char of a newline
         '{"\"",  1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},
         '{"\n",  1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},
         '{8'h00, 1'b1, 1'b1, sbl_pkg::KindError, sbl_pkg::ErrUnterminated}, // open string
         '{"/",   1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},
         '{8'hA5, 1'b1, 1'b1, sbl_pkg::KindSlash, sbl_pkg::ErrNone},    // slash flushed at end
         '{"'",   1'b0, 1'b0, 6'd0, sbl_pkg::ErrNone},
         '{8'h00, 1'b1, 1'b1, sbl_pkg::KindChar, sbl_pkg::ErrNone}      // quote right before end
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_word(rows[i].byte_val, rows[i].eos);
         if (rows[i].typed) begin
            if (step_toks.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("row %0d: want kind %0d err %0d, model gives no token",
                           i, rows[i].kind, rows[i].err);
            end else begin
               first = step_toks[0];
               if (first.kind != rows[i].kind || first.err != rows[i].err) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("row %0d: want kind %0d err %0d, model gives %0d %0d",
                              i, rows[i].kind, rows[i].err, first.kind, first.err);
               end
            end
         end
      end
      // all keywords once, then end
      foreach (kw_words[i]) send_text({kw_words[i], " "});
      send_word(8'h00, 1'b1);
      req_valid <= 1'b0;
      @(posedge clock);

      // sender pauses until the block has drained
      while (token_queue.size() != 0) @(posedge clock);

      // receiver holds off while text keeps flowing, so the input backs up
      hold_off = 1'b1;
      send_text("a;b;c;d;e;f;g;h;(){},.-+*");

      // random part: mostly well-formed text, some noise, ends of source
      for (int n = 0; n < 230; ) begin
         string s;
         case ($urandom_range(0, 9))
            0: s = string'(8'($urandom_range(0, 255)));
            1: s = string'(pick_byte());
            default: s = pick_lexeme();
         endcase
         send_text(s);
         n += s.len();
         if ($urandom_range(0, 25) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
      end
      send_word(8'h00, 1'b1);
      req_valid <= 1'b0;

      while (token_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
